@@ hw/rtl/rkm_pkg.sv @@
`default_nettype none

package rkm_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 8;
    localparam int unsigned MaxOut        = 64;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_PROTOCOL     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ACCEL_START  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ACCEL_MAX    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_ACCEL_FACTOR = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_ALWAYS_ON    = 3'd4;

    // directive codes
    localparam logic [4:0] CODE_WHEEL_OUT  = 5'd9;
    localparam logic [4:0] CODE_BTN_FIRST  = 5'd10;
    localparam logic [4:0] CODE_ACTIVATE   = 5'd22;
    localparam logic [4:0] CODE_TOGGLE_ACT = 5'd23;
    localparam logic [4:0] CODE_NO_MATCH   = 5'd24;

    // button actions, low two bits of the button code offset
    localparam logic [1:0] ACT_DOWN   = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_CLICK  = 2'd3;

    localparam logic [2:0] BTN1     = 3'h4;
    localparam logic [2:0] BTN2     = 3'h2;
    localparam logic [2:0] BTN3     = 3'h1;
    localparam logic [2:0] ALL_BTNS = 3'h7;

    localparam logic [7:0] MS_FIXED  = 8'h78;
    localparam logic [7:0] IMPS_SYNC = 8'h08;
    localparam logic [7:0] IMPS_XNEG = 8'h10;
    localparam logic [7:0] IMPS_YNEG = 8'h20;
    localparam logic [7:0] IMPS_B1   = 8'h01;
    localparam logic [7:0] IMPS_B3   = 8'h02;
    localparam logic [7:0] IMPS_B2   = 8'h04;

    localparam logic [2:0] LEN_MS   = 3'd5;
    localparam logic [2:0] LEN_IMPS = 3'd4;

    typedef struct packed {
        logic [4:0]  directive_code;
        logic [15:0] repeat_count;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packet_byte0;
        logic [7:0] packet_byte1;
        logic [7:0] packet_byte2;
        logic [7:0] packet_byte3;
        logic [7:0] packet_byte4;
        logic [2:0] packet_length;
        logic       last_packet;
    } t_out_word;

    typedef struct packed {
        logic latch;
        logic plan;
        logic apply;
        logic second;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic work;
        logic two_phase;
        logic factor_zero;
        logic count_one;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] move_dx(input logic [3:0] code);
        unique case (code)
            4'd1, 4'd2, 4'd3: move_dx = 8'h01;
            4'd5, 4'd6, 4'd7: move_dx = 8'hFF;
            default:          move_dx = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] move_dy(input logic [3:0] code);
        unique case (code)
            4'd0, 4'd1, 4'd7: move_dy = 8'h01;
            4'd3, 4'd4, 4'd5: move_dy = 8'hFF;
            default:          move_dy = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] move_dz(input logic [3:0] code);
        unique case (code)
            4'd8:    move_dz = 8'hFF;
            4'd9:    move_dz = 8'h01;
            default: move_dz = 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] btn_bit(input logic [1:0] idx);
        unique case (idx)
            2'd0:    btn_bit = BTN1;
            2'd1:    btn_bit = BTN2;
            default: btn_bit = BTN3;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rkm_in_if.sv @@
`default_nettype none

interface rkm_in_if import rkm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rkm_out_if.sv @@
`default_nettype none

interface rkm_out_if import rkm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/remote_key_mouse_packet_generator.sv @@
`default_nettype none
// An accepted word is latched, planned and applied before its first packet is loaded.
// Throughput: one packet per cycle while the sink is ready; up to 64 packets an item,
//   and a click applies its release in a second step before its release packet.
// The sequencer handles one directive at a time; a new word is taken once the
//   previous item's packets are all loaded into the output register.
// Reset (synchronous, active low): buttons released, inactive, registers at defaults.

module remote_key_mouse_packet_generator import rkm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [CfgDataWidth-1:0]  i_cfg_data,
    rkm_in_if.sink                        i_cmd,
    rkm_out_if.source                     o_pkt
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rkm_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rkm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_cmd.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_word  (o_pkt.data),
        .o_out_valid (o_pkt.valid),
        .i_out_ready (o_pkt.ready)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rkm_datapath.sv @@
`default_nettype none

module rkm_datapath import rkm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [CfgDataWidth-1:0]  i_cfg_data,
    input  wire t_in_word                 i_in_word,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_status                    o_status,
    output t_out_word                     o_out_word,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready
);

    // configuration
    logic       r_protocol;
    logic [7:0] r_accel_start;
    logic [6:0] r_accel_max;
    logic [6:0] r_accel_factor;
    logic       r_always_on;

    // block state
    logic [2:0] r_mask;
    logic       r_active;
    logic       r_toggled;

    // latched word and plan
    logic [4:0]  r_code;
    logic [15:0] r_rep;
    logic        r_work;
    logic        r_two;
    logic        r_move;
    logic [2:0]  r_press1;
    logic [2:0]  r_rel1;
    logic [2:0]  r_rel2;
    logic [6:0]  r_factor;
    logic [6:0]  r_count;

    t_out_word r_out;
    logic      r_out_valid;

    logic        p_work, p_two, p_move;
    logic [2:0]  p_press1, p_rel1, p_rel2;
    logic        p_set_active, p_clr_active, p_set_toggled;
    logic        gate;
    logic [4:0]  k;
    logic [2:0]  bsel;
    logic [15:0] rep_eff;
    logic [22:0] prod;
    logic [6:0]  mx;
    logic [6:0]  p_factor;
    logic        out_free;
    logic [2:0]  press_sel, rel_sel;
    logic [7:0]  dx, dy, dz;
    logic [7:0]  b0_imps, b0_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol     <= 1'b0;
            r_accel_start  <= 8'd2;
            r_accel_max    <= 7'd20;
            r_accel_factor <= 7'd2;
            r_always_on    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROTOCOL:     r_protocol     <= i_cfg_data[0];
                REG_ACCEL_START:  r_accel_start  <= i_cfg_data;
                REG_ACCEL_MAX:    r_accel_max    <= i_cfg_data[6:0];
                REG_ACCEL_FACTOR: r_accel_factor <= i_cfg_data[6:0];
                REG_ALWAYS_ON:    r_always_on    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode the directive against the current state
    always_comb begin
        p_work        = 1'b0;
        p_two         = 1'b0;
        p_move        = 1'b0;
        p_press1      = '0;
        p_rel1        = '0;
        p_rel2        = '0;
        p_set_active  = 1'b0;
        p_clr_active  = 1'b0;
        p_set_toggled = 1'b0;
        gate          = r_active | r_always_on;
        k             = r_code - CODE_BTN_FIRST;
        bsel          = btn_bit(k[3:2]);
        priority if (r_code > CODE_NO_MATCH) begin
            p_work = 1'b0;
        end else if (r_code == CODE_NO_MATCH) begin
            if (r_active && !r_always_on && !r_toggled) begin
                p_work       = 1'b1;
                p_rel1       = ALL_BTNS;
                p_clr_active = 1'b1;
            end
        end else if (r_code == CODE_ACTIVATE) begin
            p_set_active = !r_active && !r_always_on;
        end else if (r_code == CODE_TOGGLE_ACT) begin
            if (r_rep == 16'd0 && !r_always_on) begin
                if (!r_active) begin
                    p_set_active  = 1'b1;
                    p_set_toggled = 1'b1;
                end else begin
                    p_work       = 1'b1;
                    p_rel1       = ALL_BTNS;
                    p_clr_active = 1'b1;
                end
            end
        end else if (gate) begin
            if (r_code <= CODE_WHEEL_OUT) begin
                p_work = 1'b1;
                p_move = 1'b1;
            end else if (r_rep == 16'd0) begin
                p_work = 1'b1;
                unique case (k[1:0])
                    ACT_DOWN: p_press1 = bsel;
                    ACT_UP:   p_rel1   = bsel;
                    ACT_TOGGLE: begin
                        if ((r_mask & bsel) != 3'd0) p_rel1 = bsel;
                        else p_press1 = bsel;
                    end
                    ACT_CLICK: begin
                        p_press1 = bsel;
                        p_two    = 1'b1;
                        p_rel2   = bsel;
                    end
                    default: ;
                endcase
            end
        end
    end

    // repeat factor; button and deactivation packets count as repeat zero
    always_comb begin
        rep_eff = p_move ? r_rep : 16'd0;
        prod    = {7'd0, rep_eff} * {16'd0, r_accel_factor};
        mx      = (r_accel_max > 7'(MaxOut)) ? 7'(MaxOut) : r_accel_max;
        if (rep_eff < {8'd0, r_accel_start}) begin
            p_factor = 7'd1;
        end else if (prod >= {16'd0, mx}) begin
            p_factor = mx;
        end else begin
            p_factor = prod[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_code <= i_in_word.directive_code;
            r_rep  <= i_in_word.repeat_count;
        end
        if (i_cmd.plan) begin
            r_work   <= p_work;
            r_two    <= p_two;
            r_move   <= p_move;
            r_press1 <= p_press1;
            r_rel1   <= p_rel1;
            r_rel2   <= p_rel2;
            r_factor <= p_factor;
        end
        if (i_cmd.apply) begin
            r_count <= r_factor;
        end else if (i_cmd.emit) begin
            r_count <= r_count - 7'd1;
        end
    end

    assign press_sel = i_cmd.second ? 3'd0   : r_press1;
    assign rel_sel   = i_cmd.second ? r_rel2 : r_rel1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_active  <= 1'b0;
            r_toggled <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_mask <= (r_mask | press_sel) & ~rel_sel;
            end
            if (i_cmd.plan) begin
                if (p_set_active) r_active <= 1'b1;
                else if (p_clr_active) r_active <= 1'b0;
                if (p_set_toggled) r_toggled <= 1'b1;
            end
        end
    end

    // packet assembly from the updated mask
    always_comb begin
        dx      = r_move ? move_dx(r_code[3:0]) : 8'h00;
        dy      = r_move ? move_dy(r_code[3:0]) : 8'h00;
        dz      = r_move ? move_dz(r_code[3:0]) : 8'h00;
        b0_imps = IMPS_SYNC
                | (((r_mask & BTN1) != 3'd0) ? IMPS_B1 : 8'h00)
                | (((r_mask & BTN3) != 3'd0) ? IMPS_B3 : 8'h00)
                | (((r_mask & BTN2) != 3'd0) ? IMPS_B2 : 8'h00)
                | (dx[7] ? IMPS_XNEG : 8'h00)
                | (dy[7] ? IMPS_YNEG : 8'h00);
        b0_ms   = ~({5'd0, r_mask} | MS_FIXED);
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.packet_byte0  <= r_protocol ? b0_imps : b0_ms;
            r_out.packet_byte1  <= dx;
            r_out.packet_byte2  <= dy;
            r_out.packet_byte3  <= r_protocol ? dz : 8'h00;
            r_out.packet_byte4  <= 8'h00;
            r_out.packet_length <= r_protocol ? LEN_IMPS : LEN_MS;
            r_out.last_packet   <= i_cmd.last;
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

    assign o_status.work        = r_work;
    assign o_status.two_phase   = r_two;
    assign o_status.factor_zero = (r_factor == 7'd0);
    assign o_status.count_one   = (r_count == 7'd1);
    assign o_status.out_free    = out_free;

endmodule

`default_nettype wire

@@ hw/rtl/rkm_controller.sv @@
`default_nettype none

module rkm_controller import rkm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PLAN   = 6'b000010,
        ST_APPLY1 = 6'b000100,
        ST_EMIT1  = 6'b001000,
        ST_APPLY2 = 6'b010000,
        ST_EMIT2  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_PLAN;
                end
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = ST_APPLY1;
            end
            ST_APPLY1: begin
                o_cmd.apply = 1'b1;
                if (!i_status.work) begin
                    n_state = ST_IDLE;
                end else if (i_status.factor_zero) begin
                    n_state = i_status.two_phase ? ST_APPLY2 : ST_IDLE;
                end else begin
                    n_state = ST_EMIT1;
                end
            end
            ST_EMIT1: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_status.count_one && !i_status.two_phase;
                    if (i_status.count_one) begin
                        n_state = i_status.two_phase ? ST_APPLY2 : ST_IDLE;
                    end
                end
            end
            ST_APPLY2: begin
                o_cmd.apply  = 1'b1;
                o_cmd.second = 1'b1;
                n_state      = i_status.factor_zero ? ST_IDLE : ST_EMIT2;
            end
            ST_EMIT2: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_status.count_one;
                    if (i_status.count_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("word loaded into a full output register");

    a_accept_then_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_PLAN))
        else $error("accepted word not followed by planning");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT1) || (r_state == ST_EMIT2)) |-> !i_status.factor_zero)
        else $error("emitting with a zero repeat factor");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("last packet sent but item not finished");

endmodule

`default_nettype wire

@@ sim/tb_remote_key_mouse_packet_generator.sv @@
`timescale 1ns / 1ps

module tb_remote_key_mouse_packet_generator;
    import rkm_pkg::*;

    localparam logic [4:0] MOVE_N            = 5'd0;
    localparam logic [4:0] MOVE_E            = 5'd2;
    localparam logic [4:0] MOVE_S            = 5'd4;
    localparam logic [4:0] MOVE_SW           = 5'd5;
    localparam logic [4:0] MOVE_NW           = 5'd7;
    localparam logic [4:0] WHEEL_IN          = 5'd8;
    localparam logic [4:0] CODE_UNUSED_FIRST = 5'd25;
    localparam logic [4:0] CODE_UNUSED_LAST  = 5'd31;
    localparam int unsigned SETTLE_CYCLES    = 12;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index   = '0;
    logic [CfgDataWidth-1:0]  cfg_data    = '0;

    rkm_in_if  cmd_if ();
    rkm_out_if pkt_if ();

    remote_key_mouse_packet_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cmd       (cmd_if),
        .o_pkt       (pkt_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's registers and state
    logic       cfg_imps;
    logic [7:0] cfg_start;
    logic [6:0] cfg_max;
    logic [6:0] cfg_factor;
    logic       cfg_always_on;
    logic [2:0] btn_state;
    logic       is_active;
    logic       toggle_latched;

    int         step_x [10] = '{0, 1, 1, 1, 0, -1, -1, -1, 0, 0};
    int         step_y [10] = '{1, 1, 0, -1, -1, -1, 0, 1, 0, 0};
    int         step_z [10] = '{0, 0, 0, 0, 0, 0, 0, 0, -1, 1};
    logic [2:0] btn_of_idx [3] = '{BTN1, BTN2, BTN3};

    t_in_word   key_words [$];
    t_out_word  due_packets [$];
    t_out_word  burst_packets [$];
    t_out_word  want;
    int         mismatches = 0;
    bit         steady = 1'b0;

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 26);
    endfunction

    function automatic int unsigned repeat_factor(logic [15:0] rep);
        int unsigned cap;
        int unsigned prod;
        cap  = (cfg_max > 7'd64) ? 64 : cfg_max;
        prod = 32'(rep) * 32'(cfg_factor);
        if (rep < cfg_start) return 1;
        return (prod >= cap) ? cap : prod;
    endfunction

    function automatic void emit_packets(int dx, int dy, int dz, logic [15:0] rep,
                                         logic [2:0] press, logic [2:0] release_bits);
        int unsigned copies;
        t_out_word   w;
        copies    = repeat_factor(rep);
        btn_state = (btn_state | press) & ~release_bits;
        w = '0;
        w.packet_byte1 = 8'(dx);
        w.packet_byte2 = 8'(dy);
        if (cfg_imps) begin
            w.packet_byte0 = IMPS_SYNC;
            if (|(btn_state & BTN1)) w.packet_byte0 |= IMPS_B1;
            if (|(btn_state & BTN3)) w.packet_byte0 |= IMPS_B3;
            if (|(btn_state & BTN2)) w.packet_byte0 |= IMPS_B2;
            if (dx < 0) w.packet_byte0 |= IMPS_XNEG;
            if (dy < 0) w.packet_byte0 |= IMPS_YNEG;
            w.packet_byte3  = 8'(dz);
            w.packet_length = LEN_IMPS;
        end else begin
            w.packet_byte0  = ~({5'b0, btn_state} | MS_FIXED);
            w.packet_length = LEN_MS;
        end
        while (copies > 0 && burst_packets.size() < MaxOut) begin
            burst_packets.push_back(w);
            copies--;
        end
    endfunction

    // buttons act on the first press only
    function automatic void press_buttons(logic [2:0] press, logic [2:0] release_bits,
                                          logic [15:0] rep);
        if (rep == 16'd0) emit_packets(0, 0, 0, 16'd0, press, release_bits);
    endfunction

    function automatic void go_inactive();
        press_buttons(3'b0, ALL_BTNS, 16'd0);
        is_active = 1'b0;
    endfunction

    function automatic void predict_packets(t_in_word w);
        logic [4:0]  code;
        logic [15:0] rep;
        logic [3:0]  k;
        logic [2:0]  b;
        t_out_word   tail;
        code = w.directive_code;
        rep  = w.repeat_count;
        burst_packets.delete();
        if (code == CODE_NO_MATCH) begin
            if (is_active && !cfg_always_on && !toggle_latched) go_inactive();
        end else if (code == CODE_ACTIVATE) begin
            if (!is_active && !cfg_always_on) is_active = 1'b1;
        end else if (code == CODE_TOGGLE_ACT) begin
            if (rep == 16'd0 && !cfg_always_on) begin
                if (!is_active) begin
                    is_active      = 1'b1;
                    toggle_latched = 1'b1;
                end else begin
                    go_inactive();
                end
            end
        end else if (code < CODE_ACTIVATE && (is_active || cfg_always_on)) begin
            if (code < CODE_BTN_FIRST) begin
                emit_packets(step_x[code[3:0]], step_y[code[3:0]], step_z[code[3:0]],
                             rep, 3'b0, 3'b0);
            end else begin
                k = 4'(code - CODE_BTN_FIRST);
                b = btn_of_idx[k[3:2]];
                case (k[1:0])
                    ACT_DOWN: press_buttons(b, 3'b0, rep);
                    ACT_UP: press_buttons(3'b0, b, rep);
                    ACT_TOGGLE: begin
                        if (|(btn_state & b)) press_buttons(3'b0, b, rep);
                        else press_buttons(b, 3'b0, rep);
                    end
                    default: begin
                        press_buttons(b, 3'b0, rep);
                        press_buttons(3'b0, b, rep);
                    end
                endcase
            end
        end
        if (burst_packets.size() > 0) begin
            tail = burst_packets.pop_back();
            tail.last_packet = 1'b1;
            burst_packets.push_back(tail);
        end
        foreach (burst_packets[i]) due_packets.push_back(burst_packets[i]);
    endfunction

    function automatic void shadow_reg(logic [CfgIndexWidth-1:0] idx,
                                       logic [CfgDataWidth-1:0] val);
        case (idx)
            REG_PROTOCOL:     cfg_imps      = val[0];
            REG_ACCEL_START:  cfg_start     = val;
            REG_ACCEL_MAX:    cfg_max       = val[6:0];
            REG_ACCEL_FACTOR: cfg_factor    = val[6:0];
            REG_ALWAYS_ON:    cfg_always_on = val[0];
            default: ;
        endcase
    endfunction

    function automatic logic [4:0] btn_code(int unsigned idx, logic [1:0] act);
        return CODE_BTN_FIRST + 5'(idx * 4) + 5'(act);
    endfunction

    function automatic void queue_word(logic [4:0] code, logic [15:0] rep);
        t_in_word w;
        w.directive_code = code;
        w.repeat_count   = rep;
        key_words.push_back(w);
    endfunction

    function automatic logic [15:0] random_repeat();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'd0;
        if (r < 80) return 16'($urandom_range(1, 6));
        if (r < 90) return 16'($urandom_range(7, 300));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [4:0] random_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 5'($urandom_range(MOVE_N, CODE_WHEEL_OUT));
        if (r < 72) return 5'($urandom_range(CODE_BTN_FIRST, CODE_ACTIVATE - 1));
        if (r < 82) return CODE_ACTIVATE;
        if (r < 90) return CODE_TOGGLE_ACT;
        if (r < 96) return CODE_NO_MATCH;
        return 5'($urandom_range(CODE_UNUSED_FIRST, CODE_UNUSED_LAST));
    endfunction

    task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %02h, got %02h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    // wait for the block to drain, then let any word with no packets settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (key_words.size() > 0 || cmd_if.valid || due_packets.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        shadow_reg(idx, val);
    endtask

    task automatic set_config(logic [7:0] prot, logic [7:0] start, logic [7:0] cap,
                              logic [7:0] factor, logic [7:0] aon);
        write_reg(REG_PROTOCOL, prot);
        write_reg(REG_ACCEL_START, start);
        write_reg(REG_ACCEL_MAX, cap);
        write_reg(REG_ACCEL_FACTOR, factor);
        write_reg(REG_ALWAYS_ON, aon);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned made;
        int unsigned burst;
        logic [4:0]  code;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 15) begin
                // activate, a few actions, then drop back out
                queue_word(CODE_ACTIVATE, random_repeat());
                burst = $urandom_range(2, 6);
                for (int i = 0; i < burst; i++)
                    queue_word(5'($urandom_range(MOVE_N, CODE_ACTIVATE - 1)), random_repeat());
                queue_word(CODE_NO_MATCH, random_repeat());
                made += burst + 2;
            end else begin
                code = random_code();
                queue_word(code, random_repeat());
                if (code <= CODE_NO_MATCH) made++;
            end
        end
        wait_idle();
    endtask

    // driver: hold each word until accepted, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_if.valid) predict_packets(cmd_if.data);
            if (key_words.size() > 0 && !take_gap()) begin
                cmd_if.valid <= 1'b1;
                cmd_if.data  <= key_words.pop_front();
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each packet word with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_if.ready <= 1'b0;
        end else begin
            pkt_if.ready <= !take_gap();
            if (pkt_if.valid && pkt_if.ready) begin
                if (due_packets.size() == 0) begin
                    $error("packet word arrived with none expected");
                    mismatches++;
                end else begin
                    want = due_packets.pop_front();
                    check_field("packet_byte0", want.packet_byte0, pkt_if.data.packet_byte0);
                    check_field("packet_byte1", want.packet_byte1, pkt_if.data.packet_byte1);
                    check_field("packet_byte2", want.packet_byte2, pkt_if.data.packet_byte2);
                    check_field("packet_byte3", want.packet_byte3, pkt_if.data.packet_byte3);
                    check_field("packet_byte4", want.packet_byte4, pkt_if.data.packet_byte4);
                    check_field("packet_length", 8'(want.packet_length),
                                8'(pkt_if.data.packet_length));
                    check_field("last_packet", 8'(want.last_packet),
                                8'(pkt_if.data.last_packet));
                end
            end
        end
    end

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.data    = '0;
        pkt_if.ready   = 1'b0;
        cfg_imps       = 1'b0;
        cfg_start      = 8'd2;
        cfg_max        = 7'd20;
        cfg_factor     = 7'd2;
        cfg_always_on  = 1'b1;
        btn_state      = 3'b0;
        is_active      = 1'b0;
        toggle_latched = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: moves, wheel, buttons, ignored codes
        queue_word(MOVE_N, 16'd0);
        queue_word(MOVE_E, 16'd1);
        queue_word(MOVE_SW, 16'd2);
        queue_word(MOVE_NW, 16'hFFFF);
        queue_word(WHEEL_IN, 16'd0);
        queue_word(CODE_WHEEL_OUT, 16'd3);
        queue_word(btn_code(0, ACT_DOWN), 16'd0);
        queue_word(btn_code(1, ACT_TOGGLE), 16'd0);
        queue_word(btn_code(2, ACT_CLICK), 16'd0);
        queue_word(btn_code(0, ACT_UP), 16'd5);
        queue_word(btn_code(1, ACT_TOGGLE), 16'd0);
        queue_word(btn_code(0, ACT_UP), 16'd0);
        queue_word(CODE_UNUSED_FIRST, 16'd0);
        queue_word(CODE_UNUSED_LAST, 16'hFFFF);
        queue_word(CODE_ACTIVATE, 16'd0);
        queue_word(CODE_TOGGLE_ACT, 16'd0);
        queue_word(CODE_NO_MATCH, 16'd0);
        wait_idle();

        // activation gating, deactivation and toggled activation
        write_reg(REG_ALWAYS_ON, 8'd0);
        write_reg(REG_PROTOCOL, 8'd1);
        queue_word(MOVE_N, 16'd0);
        queue_word(CODE_ACTIVATE, 16'd0);
        queue_word(btn_code(0, ACT_DOWN), 16'd0);
        queue_word(MOVE_S, 16'd0);
        queue_word(CODE_NO_MATCH, 16'd0);
        queue_word(CODE_TOGGLE_ACT, 16'd0);
        queue_word(CODE_NO_MATCH, 16'd0);
        queue_word(btn_code(2, ACT_DOWN), 16'd0);
        queue_word(CODE_TOGGLE_ACT, 16'd1);
        queue_word(CODE_TOGGLE_ACT, 16'd0);
        wait_idle();

        random_phase(60);
        set_config(8'd0, 8'd0, 8'd64, 8'd64, 8'd1);
        steady = 1'b1;
        random_phase(60);
        steady = 1'b0;
        set_config(8'd1, 8'd255, 8'd127, 8'd127, 8'd1);
        random_phase(60);
        set_config(8'd0, 8'd1, 8'd0, 8'd1, 8'd0);
        random_phase(60);
        set_config(8'd1, 8'd3, 8'd64, 8'd0, 8'd0);
        random_phase(60);
        repeat (3) begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            random_phase(40);
        end

        if (mismatches == 0 && due_packets.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
